// ----- src/box_delta_decode_clip_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the box delta decoder.
// Simulation builds get concurrent assertions, synthesis builds get nothing.
// ---------------------------------------------------------------------------
`ifndef BOX_DELTA_DECODE_CLIP_ASSERT_SVH
`define BOX_DELTA_DECODE_CLIP_ASSERT_SVH
`ifndef SYNTH
`define BDDC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("box delta decode assertion failed");
`define BDDC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("box delta decode assertion failed");
`else
`define BDDC_ASSERT_IMP(label, ante, cons)
`define BDDC_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- src/bddc_pkg.sv -----
// ---------------------------------------------------------------------------
// Box delta decode package
// Shared constants, register map and the divider step function.
// ---------------------------------------------------------------------------
`default_nettype none
package bddc_pkg;
	localparam int DIV_STAGES  = 16;
	localparam int AXIS_STAGES = 7;
	localparam int PIPE_DEPTH  = DIV_STAGES + AXIS_STAGES;

	localparam logic [1:0] REG_HEIGHT = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_SCALE  = 2'd2;

	localparam logic [12:0] HEIGHT_RST = 13'd4096;
	localparam logic [12:0] WIDTH_RST  = 13'd4096;
	localparam logic [23:0] SCALE_RST  = 24'd65536;

	localparam logic signed [17:0] LOG2E_Q16 = 18'sd94549;
	localparam logic [12:0] EXP_C3 = 13'd5106;
	localparam logic [16:0] EXP_C2 = 17'd14815;
	localparam logic [17:0] EXP_C1 = 18'd45602;
	localparam logic [17:0] EXP_C0 = 18'd65536;

	// One restoring division step: returns the new remainder and the quotient bit.
	function automatic logic [24:0] div_step(input logic [23:0] rem, input logic nb,
		input logic [23:0] dvs);
		logic [24:0] r;
		logic [24:0] d;
		logic [24:0] res;
		r = {rem, nb};
		d = {1'b0, dvs};
		if (r >= d) begin
			res = {24'(r - d), 1'b1};
		end else begin
			res = {r[23:0], 1'b0};
		end
		return res;
	endfunction
endpackage
`default_nettype wire

// ----- src/bddc_div.sv -----
// ---------------------------------------------------------------------------
// Pipelined coordinate divider
// Computes (coord << 16) / divisor with two quotient bits per stage.
// ---------------------------------------------------------------------------
`default_nettype none
module bddc_div (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [15:0] coord,
	input  wire logic [23:0] divisor,
	output logic      [31:0] quo
);
	logic [23:0] rem_s [bddc_pkg::DIV_STAGES];
	logic [31:0] num_s [bddc_pkg::DIV_STAGES];
	logic [31:0] quo_s [bddc_pkg::DIV_STAGES];

	for (genvar g = 0; g < bddc_pkg::DIV_STAGES; g++) begin : g_stage
		logic [23:0] r_in;
		logic [31:0] n_in;
		logic [31:0] q_in;
		logic [24:0] st_a;
		logic [24:0] st_b;
		if (g == 0) begin : g_first
			assign r_in = '0;
			assign n_in = {coord, 16'h0000};
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[g-1];
			assign n_in = num_s[g-1];
			assign q_in = quo_s[g-1];
		end
		assign st_a = bddc_pkg::div_step(r_in, n_in[31], divisor);
		assign st_b = bddc_pkg::div_step(st_a[24:1], n_in[30], divisor);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= st_b[24:1];
				num_s[g] <= {n_in[29:0], 2'b00};
				quo_s[g] <= {q_in[29:0], st_a[0], st_b[0]};
			end
		end
	end

	assign quo = quo_s[bddc_pkg::DIV_STAGES-1];
endmodule
`default_nettype wire

// ----- src/bddc_axis.sv -----
// ---------------------------------------------------------------------------
// Axis decoder
// Applies the centre shift and the exponential size delta to one axis, then
// clamps both corners to the image.
// ---------------------------------------------------------------------------
`default_nettype none
module bddc_axis (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic        [31:0] c1,
	input  wire logic        [31:0] c2,
	input  wire logic signed [15:0] shift,
	input  wire logic signed [15:0] logd,
	input  wire logic        [12:0] dim,
	output logic             [15:0] lo,
	output logic             [15:0] hi
);
	logic signed [33:0] size_s1, size_s2, size_s3, size_s4;
	logic signed [34:0] ctr_s1, ctr_s2;
	logic signed [33:0] y_s1;
	logic signed [15:0] shift_s1;
	logic signed [49:0] prod_s2;
	logic signed [5:0]  n_s2, n_s3, n_s4, n_s5;
	logic        [15:0] f_s2, f_s3;
	logic        [16:0] m1_s2;
	logic signed [39:0] ctr_s3, ctr_s4, ctr_s5, ctr_s6;
	logic        [17:0] m2_s3, m3_s4;
	logic signed [52:0] p_s5;
	logic signed [52:0] ns_s6;
	logic        [15:0] lo_s7, hi_s7;

	logic        [28:0] t1;
	logic        [32:0] t2;
	logic        [33:0] t3;
	logic signed [5:0]  sh;
	logic        [15:0] bound;
	logic signed [53:0] lo5, hi5;

	always_ff @(posedge clk) begin
		if (en) begin
			size_s1  <= $signed({2'b00, c2}) - $signed({2'b00, c1}) + 34'sd16;
			ctr_s1   <= $signed({3'b000, c1} + {3'b000, c2} + 35'd16);
			y_s1     <= logd * bddc_pkg::LOG2E_Q16;
			shift_s1 <= shift;
		end
	end

	assign t1 = y_s1[27:12] * bddc_pkg::EXP_C3;
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= shift_s1 * size_s1;
			n_s2    <= y_s1[33:28];
			f_s2    <= y_s1[27:12];
			m1_s2   <= 17'(t1[28:16]) + bddc_pkg::EXP_C2;
			size_s2 <= size_s1;
			ctr_s2  <= ctr_s1;
		end
	end

	assign t2 = m1_s2 * f_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			ctr_s3  <= 40'(ctr_s2) + 40'(prod_s2 >>> 11);
			m2_s3   <= {1'b0, t2[32:16]} + bddc_pkg::EXP_C1;
			f_s3    <= f_s2;
			n_s3    <= n_s2;
			size_s3 <= size_s2;
		end
	end

	assign t3 = m2_s3 * f_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			m3_s4   <= 18'(t3[33:16]) + bddc_pkg::EXP_C0;
			n_s4    <= n_s3;
			size_s4 <= size_s3;
			ctr_s4  <= ctr_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s5   <= size_s4 * $signed({1'b0, m3_s4});
			n_s5   <= n_s4;
			ctr_s5 <= ctr_s4;
		end
	end

	assign sh = 6'sd16 - n_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			ns_s6  <= p_s5 >>> sh[4:0];
			ctr_s6 <= ctr_s5;
		end
	end

	assign bound = (dim > 13'd4096) ? 16'hFFFF : {12'(dim - 13'd1), 4'h0};
	assign lo5 = 54'(ctr_s6) - 54'(ns_s6);
	assign hi5 = 54'(ctr_s6) + 54'(ns_s6);

	function automatic logic [15:0] clamp(input logic signed [53:0] v5,
		input logic [15:0] bnd, input logic zero_dim);
		logic signed [52:0] v4;
		logic [15:0] res;
		v4 = v5[53:1];
		if (zero_dim || v4[52]) begin
			res = 16'h0000;
		end else if (v4 > $signed({37'b0, bnd})) begin
			res = bnd;
		end else begin
			res = v4[15:0];
		end
		return res;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s7 <= clamp(lo5, bound, dim == 13'd0);
			hi_s7 <= clamp(hi5, bound, dim == 13'd0);
		end
	end

	assign lo = lo_s7;
	assign hi = hi_s7;
endmodule
`default_nettype wire

// ----- src/box_delta_decode_clip.sv -----
// Pipeline: 16 divider stages and 7 axis stages between input transaction and result.
// Throughput: one transaction per cycle; the whole pipeline holds while the output stalls.
// The divider retires two quotient bits per stage, which sets the pipeline depth.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// ---------------------------------------------------------------------------
// Box delta decode and clip
// Top level: register port, divider pipes, delay lines and axis decoders.
// ---------------------------------------------------------------------------
`default_nettype none
module box_delta_decode_clip (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] box_left,
	input  wire logic [15:0] box_top,
	input  wire logic [15:0] box_right,
	input  wire logic [15:0] box_bottom,
	input  wire logic signed [15:0] shift_x,
	input  wire logic signed [15:0] shift_y,
	input  wire logic signed [15:0] log_scale_w,
	input  wire logic signed [15:0] log_scale_h,
	input  wire logic        last_box,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [15:0] out_left,
	output logic      [15:0] out_top,
	output logic      [15:0] out_right,
	output logic      [15:0] out_bottom,
	output logic             out_last
);
	localparam int DS = bddc_pkg::DIV_STAGES;
	localparam int PD = bddc_pkg::PIPE_DEPTH;

	logic [12:0] image_height_q;
	logic [12:0] image_width_q;
	logic [23:0] resize_scale_q;
	logic [PD-1:0] vld_q;
	logic en;
	logic [23:0] divisor;
	logic [31:0] q_left, q_top, q_right, q_bottom;
	logic signed [15:0] shx_s [DS];
	logic signed [15:0] shy_s [DS];
	logic signed [15:0] lgw_s [DS];
	logic signed [15:0] lgh_s [DS];
	logic last_s [PD];

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_height_q <= bddc_pkg::HEIGHT_RST;
			image_width_q  <= bddc_pkg::WIDTH_RST;
			resize_scale_q <= bddc_pkg::SCALE_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				bddc_pkg::REG_HEIGHT: image_height_q <= pwdata[12:0];
				bddc_pkg::REG_WIDTH:  image_width_q  <= pwdata[12:0];
				bddc_pkg::REG_SCALE:  resize_scale_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			bddc_pkg::REG_HEIGHT: prdata = {19'h0, image_height_q};
			bddc_pkg::REG_WIDTH:  prdata = {19'h0, image_width_q};
			bddc_pkg::REG_SCALE:  prdata = {8'h0, resize_scale_q};
			default:              prdata = 32'h0;
		endcase
	end

	assign en        = !vld_q[PD-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[PD-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PD-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			shx_s[0] <= shift_x;
			shy_s[0] <= shift_y;
			lgw_s[0] <= log_scale_w;
			lgh_s[0] <= log_scale_h;
			last_s[0] <= last_box;
			for (int i = 1; i < DS; i++) begin
				shx_s[i] <= shx_s[i-1];
				shy_s[i] <= shy_s[i-1];
				lgw_s[i] <= lgw_s[i-1];
				lgh_s[i] <= lgh_s[i-1];
			end
			for (int i = 1; i < PD; i++) begin
				last_s[i] <= last_s[i-1];
			end
		end
	end

	assign divisor = (resize_scale_q == 24'd0) ? 24'd1 : resize_scale_q;

	bddc_div u_div_left (.clk(clk), .en(en), .coord(box_left), .divisor(divisor),
		.quo(q_left));
	bddc_div u_div_top (.clk(clk), .en(en), .coord(box_top), .divisor(divisor),
		.quo(q_top));
	bddc_div u_div_right (.clk(clk), .en(en), .coord(box_right), .divisor(divisor),
		.quo(q_right));
	bddc_div u_div_bottom (.clk(clk), .en(en), .coord(box_bottom), .divisor(divisor),
		.quo(q_bottom));

	bddc_axis u_axis_x (
		.clk(clk), .en(en), .c1(q_left), .c2(q_right),
		.shift(shx_s[DS-1]), .logd(lgw_s[DS-1]), .dim(image_width_q),
		.lo(out_left), .hi(out_right)
	);
	bddc_axis u_axis_y (
		.clk(clk), .en(en), .c1(q_top), .c2(q_bottom),
		.shift(shy_s[DS-1]), .logd(lgh_s[DS-1]), .dim(image_height_q),
		.lo(out_top), .hi(out_bottom)
	);

	assign out_last = last_s[PD-1];

`include "box_delta_decode_clip_assert.svh"
	`BDDC_ASSERT_NXT(a_stall_holds_pipe, out_valid && !out_ready, $stable(vld_q))
	`BDDC_ASSERT_IMP(a_zero_width, out_valid && image_width_q == 13'd0, out_left == 16'h0 && out_right == 16'h0)
	`BDDC_ASSERT_IMP(a_zero_height, out_valid && image_height_q == 13'd0, out_top == 16'h0 && out_bottom == 16'h0)
	`BDDC_ASSERT_IMP(a_width_bound, out_valid && image_width_q == 13'd1, out_left == 16'h0 && out_right == 16'h0)
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// ---------------------------------------------------------------------------
// Box delta decode and clip testbench
// Sends region proposals with regression deltas through the decoder under
// several register settings and random handshake idling. Each refined box
// is predicted in fixed point and compared field by field with the result.
// ---------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] left, top, right, bottom;
		logic        last;
	} box_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_ready;
	logic [15:0] box_left = '0, box_top = '0, box_right = '0, box_bottom = '0;
	logic signed [15:0] shift_x = '0, shift_y = '0, log_scale_w = '0, log_scale_h = '0;
	logic last_box = 1'b0;
	logic out_valid, out_ready = 1'b0;
	logic [15:0] out_left, out_top, out_right, out_bottom;
	logic out_last;

	logic [12:0] cur_height = bddc_pkg::HEIGHT_RST;
	logic [12:0] cur_width = bddc_pkg::WIDTH_RST;
	logic [23:0] cur_scale = bddc_pkg::SCALE_RST;

	box_t expected_boxes[$];
	int mismatches = 0;
	int boxes_sent = 0;
	int boxes_checked = 0;
	int idle_cycles = 0;
	bit calm_sink = 1'b0;
	bit sink_hold = 1'b0;
	bit calm_source = 1'b0;

	box_delta_decode_clip i_dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic longint floor_div_pow2(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -((-v + ((64'sd1 <<< s) - 1)) >>> s);
	endfunction

	function automatic longint exp_scaled(longint size, logic signed [15:0] d);
		longint y, n, sh;
		longint unsigned f, m;
		y = longint'(d) * 94549;
		n = floor_div_pow2(y, 28);
		f = (unsigned'(y) & ((64'd1 << 28) - 1)) >> 12;
		m = 5106;
		m = ((m * f) >> 16) + 14815;
		m = ((m * f) >> 16) + 45602;
		m = ((m * f) >> 16) + 65536;
		sh = 16 - n;
		if (sh < 0) sh = 0;
		if (sh > 40) sh = 40;
		return floor_div_pow2(size * longint'(m), int'(sh));
	endfunction

	function automatic logic [15:0] clip_corner(longint v5, logic [12:0] dim);
		longint v4, hi;
		v4 = floor_div_pow2(v5, 1);
		hi = (longint'(dim) - 1) * 16;
		if (hi > 65535) hi = 65535;
		if (v4 > hi) v4 = hi;
		if (v4 < 0) v4 = 0;
		return 16'(v4);
	endfunction

	task automatic refine_axis(input logic [15:0] a, input logic [15:0] b,
		input logic signed [15:0] sh, input logic signed [15:0] ld, input logic [12:0] dim,
		output logic [15:0] lo, output logic [15:0] hi);
		longint unsigned sc;
		longint c1, c2, size, ctr, ns;
		sc = (cur_scale == 0) ? 1 : cur_scale;
		c1 = longint'((64'(a) << 16) / sc);
		c2 = longint'((64'(b) << 16) / sc);
		size = c2 - c1 + 16;
		ctr = 2 * c1 + size + floor_div_pow2(longint'(sh) * size, 11);
		ns = exp_scaled(size, ld);
		lo = clip_corner(ctr - ns, dim);
		hi = clip_corner(ctr + ns, dim);
	endtask

	task automatic send_box(input logic [15:0] l, t, r, b,
		input logic signed [15:0] dx, dy, dw, dh, input logic lst);
		box_t e;
		while (!calm_source && $urandom_range(99) < 32)
			@(negedge clk);
		refine_axis(l, r, dx, dw, cur_width, e.left, e.right);
		refine_axis(t, b, dy, dh, cur_height, e.top, e.bottom);
		e.last = lst;
		box_left <= l; box_top <= t; box_right <= r; box_bottom <= b;
		shift_x <= dx; shift_y <= dy; log_scale_w <= dw; log_scale_h <= dh;
		last_box <= lst;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_boxes = {expected_boxes, e};
		boxes_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_random_box();
		logic [15:0] l, t;
		if ($urandom_range(9) < 8) begin
			l = 16'($urandom_range(16000));
			t = 16'($urandom_range(16000));
			send_box(l, t, l + 16'($urandom_range(8000)), t + 16'($urandom_range(8000)),
				16'($signed($urandom_range(4096)) - 2048),
				16'($signed($urandom_range(4096)) - 2048),
				16'($signed($urandom_range(8192)) - 4096),
				16'($signed($urandom_range(8192)) - 4096), 1'($urandom));
		end else begin
			send_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			bddc_pkg::REG_HEIGHT: cur_height = value[12:0];
			bddc_pkg::REG_WIDTH:  cur_width = value[12:0];
			bddc_pkg::REG_SCALE:  cur_scale = value[23:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_boxes.size() != 0)
			@(negedge clk);
		repeat (bddc_pkg::PIPE_DEPTH + 4) @(negedge clk);
	endtask

	task automatic test_directed();
		send_box(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
			16'sh8000, 1'b1);
		send_box(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'sh8000, 16'sh7FFF, 16'sh8000,
			16'sh7FFF, 1'b0);
		send_box(16'd160, 16'd320, 16'd800, 16'd960, 0, 0, 0, 0, 1'b0);
		send_box(16'd100, 16'd100, 16'd100, 16'd100, 16'sd4096, -16'sd4096, 16'sd4096,
			-16'sd4096, 1'b1);
		send_box(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'sh5555, 16'shAAAA, 16'sh5555,
			16'shAAAA, 1'b0);
		send_box(16'd0, 16'd0, 16'd16, 16'd16, 0, 0, 16'sd32767, 16'sd32767, 1'b1);
	endtask

	task automatic test_settings(input logic [12:0] h, input logic [12:0] w,
		input logic [23:0] s, input int count);
		wait_drained();
		write_reg(bddc_pkg::REG_HEIGHT, 32'(h));
		write_reg(bddc_pkg::REG_WIDTH, 32'(w));
		write_reg(bddc_pkg::REG_SCALE, 32'(s));
		test_directed();
		repeat (count) send_random_box();
	endtask

	task automatic test_backpressure();
		wait_drained();
		sink_hold = 1'b1;
		calm_source = 1'b1;
		fork
			repeat (3 * bddc_pkg::PIPE_DEPTH) send_random_box();
			begin
				repeat (200) @(posedge clk);
				sink_hold = 1'b0;
			end
		join
		calm_source = 1'b0;
	endtask

	task automatic test_no_idling();
		calm_sink = 1'b1;
		calm_source = 1'b1;
		repeat (150) send_random_box();
		calm_sink = 1'b0;
		calm_source = 1'b0;
	endtask

	always @(negedge clk) begin
		out_ready <= !sink_hold && (calm_sink || $urandom_range(99) >= 32);
	end

	always @(posedge clk) begin
		box_t e;
		box_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{out_left, out_top, out_right, out_bottom, out_last};
			if (expected_boxes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected transaction: %p", got);
			end else begin
				e = expected_boxes.pop_front();
				boxes_checked++;
				if (got !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %p, got %p", e, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles > 5000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_settings(13'd1, 13'd1, 24'd0, 60);
		test_settings(13'd0, 13'd0, 24'd1, 60);
		test_settings(13'd8191, 13'd8191, 24'hFFFFFF, 80);
		test_settings(13'd480, 13'd640, 24'd98304, 250);
		test_backpressure();
		test_no_idling();
		test_settings(13'd4096, 13'd4096, 24'd65536, 250);
		wait_drained();
		$display("Decoded %0d proposals, %0d results checked, across several image sizes",
			boxes_sent, boxes_checked);
		$display("and scales with random idling and a long output stall.");
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
